// ----- design/nfr_pkg.sv -----
// Package for the nearest-frame resampler: widths, register indexes and
// fixed-point constants. No dependencies; used by nearest_frame_resampler.
package nfr_pkg;

    // default frame width, all channels packed
    localparam int FRAME_BITS_DEF = 64;

    // phase accumulator, unsigned Q1.32
    localparam int PHASE_W   = 33;
    localparam int STEP_W    = 32;

    // longest run of repeated frames for one input word
    localparam int RUN_MAX   = 64;
    localparam int RUN_CNT_W = $clog2(RUN_MAX);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MODE_UP    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = CFG_IDX_W'(1);

    // reset values and phase constants
    localparam logic               MODE_UP_RST    = 1'b1;
    localparam logic [STEP_W-1:0]  PHASE_STEP_RST = 32'h8000_0000;
    localparam logic [PHASE_W-1:0] PHASE_ZERO     = 33'h0_0000_0000;
    localparam logic [PHASE_W-1:0] PHASE_ONE      = 33'h1_0000_0000;

endpackage

// ----- design/nearest_frame_resampler.sv -----
// Top level of the nearest-frame resampler: handshake, sequencer, phase
// accumulator with its shared adder, and the output register.
// Depends on nfr_pkg.

// Nearest-neighbor frame resampler. Each input word is one packed audio frame;
// the block answers with zero or more copies of it, tagged last_of_run on the
// final copy. A phase accumulator in unsigned Q1.32 (1.0 = 2^32) decides the
// count. With mode_up = 1 a frame is repeated, phase_step added per copy, until
// the phase reaches 1.0 (then 1.0 is subtracted) or 64 copies have been sent.
// With mode_up = 0 each frame adds phase_step once and is passed on only when
// the phase reaches 1.0. Writing mode_up reloads the phase (0 up, 1.0 down).
// Timing: one 33-bit adder is stepped once per cycle by a two-state sequencer
// while it runs and the output is free. An input word is accepted while idle;
// in up mode one copy then goes out per step, N = 1..64 copies per item, and
// in down mode at most one. in_ready is low while a word is being worked on.
// An output register separates the consumer, so a new input is taken while
// the last copy still waits to be read.
module nearest_frame_resampler #(
    parameter int FRAME_BITS = nfr_pkg::FRAME_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_we,
    input  logic [nfr_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [nfr_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [FRAME_BITS-1:0]          frame_in,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [FRAME_BITS-1:0]          frame_out,
    output logic                           last_of_run
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                              state_reg, state_next;
    logic                              mode_up_reg, mode_up_next;
    logic [nfr_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [nfr_pkg::PHASE_W-1:0]       phase_reg, phase_next;
    logic [nfr_pkg::RUN_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [FRAME_BITS-1:0]             frame_reg, frame_next;
    logic                              out_valid_reg, out_valid_next;
    logic [FRAME_BITS-1:0]             out_frame_reg, out_frame_next;
    logic                              out_last_reg, out_last_next;

    logic                              in_acc;
    logic                              out_free;
    logic                              step_go;
    logic [nfr_pkg::PHASE_W-1:0]       sum;
    logic                              sum_ge_one;
    logic [nfr_pkg::PHASE_W-1:0]       sum_wrapped;
    logic                              cnt_full;

    // shared phase adder, 33-bit wrap, and the 1.0 crossing
    assign sum         = phase_reg + {1'b0, step_reg};
    assign sum_ge_one  = sum[nfr_pkg::PHASE_W-1];
    assign sum_wrapped = {1'b0, sum[nfr_pkg::PHASE_W-2:0]};
    assign cnt_full    = (cnt_reg == nfr_pkg::RUN_CNT_W'(nfr_pkg::RUN_MAX - 1));

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign step_go  = (state_reg == ST_RUN) && out_free;

    // sequencer, phase update and output load
    always_comb
    begin
        state_next     = state_reg;
        mode_up_next   = mode_up_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        frame_next     = frame_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_frame_next = out_frame_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    frame_next = frame_in;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step_go)
                begin
                    phase_next = sum_ge_one ? sum_wrapped : sum;
                    if (mode_up_reg)
                    begin
                        // one copy per cycle while the output is free, until 1.0 or the run cap
                        out_valid_next = 1'b1;
                        out_frame_next = frame_reg;
                        out_last_next  = sum_ge_one || cnt_full;
                        cnt_next       = cnt_reg + 1'b1;
                        if (sum_ge_one || cnt_full)
                            state_next = ST_IDLE;
                    end
                    else
                    begin
                        // at most one copy, only on the 1.0 crossing
                        if (sum_ge_one)
                        begin
                            out_valid_next = 1'b1;
                            out_frame_next = frame_reg;
                            out_last_next  = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // register writes; the user must write only while idle, the block does not enforce it
        if (cfg_we)
        begin
            case (cfg_idx)
                nfr_pkg::REG_MODE_UP:
                begin
                    mode_up_next = cfg_data[0];
                    phase_next   = cfg_data[0] ? nfr_pkg::PHASE_ZERO : nfr_pkg::PHASE_ONE;
                end
                nfr_pkg::REG_PHASE_STEP:
                begin
                    step_next = cfg_data[nfr_pkg::STEP_W-1:0];
                end
                default:
                begin
                    step_next = step_reg;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_up_reg   <= nfr_pkg::MODE_UP_RST;
            step_reg      <= nfr_pkg::PHASE_STEP_RST;
            phase_reg     <= nfr_pkg::PHASE_ZERO;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_up_reg   <= mode_up_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        frame_reg     <= frame_next;
        out_frame_reg <= out_frame_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign frame_out   = out_frame_reg;
    assign last_of_run = out_last_reg;

`ifndef SYNTHESIS
    // up mode rests below 1.0 between words
    a_up_phase_below_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && mode_up_reg) |-> !phase_reg[nfr_pkg::PHASE_W-1])
        else $error("up-mode phase at or above 1.0 while idle");

    // down mode rests at or below 1.0 between words
    a_down_phase_max_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !mode_up_reg) |->
        (!phase_reg[nfr_pkg::PHASE_W-1] || phase_reg[nfr_pkg::PHASE_W-2:0] == '0))
        else $error("down-mode phase above 1.0 while idle");

    // an accepted word starts a run
    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_RUN && cnt_reg == '0))
        else $error("accepted word did not start a run");

    // a down-mode copy is always the last of its run
    a_down_single_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && !mode_up_reg && sum_ge_one) |=> (out_valid_reg && out_last_reg))
        else $error("down-mode copy not flagged last");
`endif

endmodule
